>>> design/sha1pd_pkg.sv
// sha1pd_pkg: constants, types and helper functions for the sha-1 password derivation
// used by every file of the block but the stream interface; depends on nothing
package sha1pd_pkg;

	localparam int unsigned UidW = 56;
	localparam int unsigned LenW = 8;
	localparam int unsigned PwdW = 32;
	localparam int unsigned Rounds = 80;
	localparam int unsigned RndsPerStage = 2;
	localparam int unsigned Stages = Rounds / RndsPerStage;
	localparam int unsigned DigestBytes = 20;
	localparam logic [LenW-1:0] UidBytes = 8'd7;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	localparam logic [4:0] Off1 = 5'd5;
	localparam logic [4:0] Off2 = 5'd13;
	localparam logic [4:0] Off3 = 5'd17;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} sha_state_t;

	// message schedule as a 16-word window
	typedef logic [15:0][31:0] sched_t;

	typedef struct packed {
		logic [PwdW-1:0] password;
		logic            derive_ok;
	} result_t;

	function automatic logic [31:0] rotl1(input logic [31:0] x);
		return {x[30:0], x[31]};
	endfunction

	// one sha-1 round; rnd selects function and constant
	function automatic sha_state_t sha_round(input sha_state_t s, input logic [31:0] w,
			input logic [6:0] rnd);
		logic [31:0] f;
		logic [31:0] k;
		logic [31:0] t;
		sha_state_t  n;
		if (rnd < 7'd20) begin
			f = (s.b & s.c) | (~s.b & s.d);
			k = 32'h5A827999;
		end else if (rnd < 7'd40) begin
			f = s.b ^ s.c ^ s.d;
			k = 32'h6ED9EBA1;
		end else if (rnd < 7'd60) begin
			f = (s.b & s.c) | (s.b & s.d) | (s.c & s.d);
			k = 32'h8F1BBCDC;
		end else begin
			f = s.b ^ s.c ^ s.d;
			k = 32'hCA62C1D6;
		end
		t = {s.a[26:0], s.a[31:27]} + f + s.e + k + w;
		n.e = s.d;
		n.d = s.c;
		n.c = {s.b[1:0], s.b[31:2]};
		n.b = s.a;
		n.a = t;
		return n;
	endfunction

	// slide the schedule window by one word
	function automatic sched_t sched_next(input sched_t w);
		sched_t n;
		n[14:0] = w[15:1];
		n[15] = rotl1(w[13] ^ w[8] ^ w[2] ^ w[0]);
		return n;
	endfunction

	// byte i of the 20-byte digest
	function automatic logic [7:0] dig_byte(input logic [159:0] dig, input logic [4:0] i);
		logic [7:0] r;
		r = 8'h00;
		for (int j = 0; j < DigestBytes; j++) begin
			if (i == 5'(j))
				r = dig[159-8*j -: 8];
		end
		return r;
	endfunction

	// (a + b) mod 20 for a, b below 20
	function automatic logic [4:0] add_mod20(input logic [4:0] a, input logic [4:0] b);
		logic [5:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 6'd20)
			s = s - 6'd20;
		return s[4:0];
	endfunction

endpackage

>>> design/sha1pd_stream_if.sv
// sha1pd_stream_if: valid/ready channel carrying one payload
// depends on nothing
interface sha1pd_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/sha1pd_round_stage.sv
// sha1pd_round_stage: two sha-1 rounds and schedule update between registers
// depends on sha1pd_pkg
module sha1pd_round_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic [6:0]                rnd,
	input  logic                      vld_in,
	input  sha1pd_pkg::sha_state_t    st_in,
	input  sha1pd_pkg::sched_t        w_in,
	input  logic                      ok_in,
	output logic                      vld_s1,
	output sha1pd_pkg::sha_state_t    st_s1,
	output sha1pd_pkg::sched_t        w_s1,
	output logic                      ok_s1
);
	sha1pd_pkg::sha_state_t st_mid;
	sha1pd_pkg::sha_state_t st_nxt;
	sha1pd_pkg::sched_t     w_mid;

	always_comb begin
		st_mid = sha1pd_pkg::sha_round(st_in, w_in[0], rnd);
		w_mid  = sha1pd_pkg::sched_next(w_in);
		st_nxt = sha1pd_pkg::sha_round(st_mid, w_mid[0], rnd + 7'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1 <= st_nxt;
			w_s1  <= sha1pd_pkg::sched_next(w_mid);
			ok_s1 <= ok_in;
		end
	end
endmodule

>>> design/sha1pd_select.sv
// sha1pd_select: final digest addition and password byte selection, two stages
// depends on sha1pd_pkg
module sha1pd_select (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   vld_in,
	input  sha1pd_pkg::sha_state_t st_in,
	input  logic                   ok_in,
	output logic                   vld_s2,
	output sha1pd_pkg::result_t    res_s2
);
	logic [159:0] dig_s1;
	logic [4:0]   base_s1;
	logic         ok_s1;
	logic         vld_s1;
	logic [159:0] dig;
	logic [7:0]   b0;
	logic [3:0]   b0_q;
	logic [4:0]   base;
	sha1pd_pkg::result_t res;

	always_comb begin
		dig = {st_in.a + sha1pd_pkg::H0, st_in.b + sha1pd_pkg::H1,
			st_in.c + sha1pd_pkg::H2, st_in.d + sha1pd_pkg::H3,
			st_in.e + sha1pd_pkg::H4};
		b0 = dig[159:152];
		// quotient by 20 through reciprocal multiply, exact for a byte
		b0_q = 4'((16'(b0) * 16'd205) >> 12);
		base = 5'(b0 - 8'(b0_q) * 8'd20);
	end

	always_comb begin
		res.derive_ok = ok_s1;
		res.password  = '0;
		if (ok_s1) begin
			res.password = {
				sha1pd_pkg::dig_byte(dig_s1, base_s1),
				sha1pd_pkg::dig_byte(dig_s1,
					sha1pd_pkg::add_mod20(base_s1, sha1pd_pkg::Off1)),
				sha1pd_pkg::dig_byte(dig_s1,
					sha1pd_pkg::add_mod20(base_s1, sha1pd_pkg::Off2)),
				sha1pd_pkg::dig_byte(dig_s1,
					sha1pd_pkg::add_mod20(base_s1, sha1pd_pkg::Off3))};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dig_s1  <= dig;
			base_s1 <= base;
			ok_s1   <= ok_in;
			res_s2  <= res;
		end
	end
endmodule

>>> design/sha1_uid_password_derive.sv
// sha1_uid_password_derive: top level of the sha-1 uid password derivation pipeline
// depends on sha1pd_pkg, sha1pd_stream_if, sha1pd_round_stage, sha1pd_select
//
// usage:
//   in_req  (sink)   request payload {tag_uid, uid_length}; taken when valid and ready
//   out_res (source) result payload {password, derive_ok}; one result per request
// a request with uid_length other than 7 gives password 0 and derive_ok 0
// from the accepting edge to the result on out_res: the input register loads at
//   the accepting edge, then 40 round stages of two sha-1 rounds each, the digest
//   add stage and the selection stage
// throughput: one request per cycle while out_res does not stall; set by the 40-stage round pipeline
// the whole pipeline advances when the output stage is empty or taken, so a stall
// on out_res holds every stage and in_req ready drops; nothing is lost or repeated
// reset clears all valid bits; the block then accepts at once
//
module sha1_uid_password_derive (
	input  logic               clk,
	input  logic               arst_n,
	sha1pd_stream_if.sink      in_req,
	sha1pd_stream_if.source    out_res
);
	localparam int unsigned NS = sha1pd_pkg::Stages;

	logic adv;
	logic                   vld_s [NS+1];
	sha1pd_pkg::sha_state_t st_s  [NS+1];
	sha1pd_pkg::sched_t     w_s   [NS+1];
	logic                   ok_s  [NS+1];
	logic                   out_vld;

	assign adv          = !out_vld || out_res.ready;
	assign in_req.ready = adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0] <= '{a: sha1pd_pkg::H0, b: sha1pd_pkg::H1, c: sha1pd_pkg::H2,
				d: sha1pd_pkg::H3, e: sha1pd_pkg::H4};
			w_s[0] <= {32'd56, 416'h0, {in_req.data.tag_uid[23:0], 8'h80},
				in_req.data.tag_uid[55:24]};
			ok_s[0] <= (in_req.data.uid_length == sha1pd_pkg::UidBytes);
		end
	end

	for (genvar g = 0; g < NS; g++) begin : g_rnd
		sha1pd_round_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.rnd    (7'(g * sha1pd_pkg::RndsPerStage)),
			.vld_in (vld_s[g]),
			.st_in  (st_s[g]),
			.w_in   (w_s[g]),
			.ok_in  (ok_s[g]),
			.vld_s1 (vld_s[g+1]),
			.st_s1  (st_s[g+1]),
			.w_s1   (w_s[g+1]),
			.ok_s1  (ok_s[g+1])
		);
	end

	sha1pd_select u_sel (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_in (vld_s[NS]),
		.st_in  (st_s[NS]),
		.ok_in  (ok_s[NS]),
		.vld_s2 (out_vld),
		.res_s2 (out_res.data)
	);

	assign out_res.valid = out_vld;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_res.valid && !out_res.ready |=> out_res.valid && $stable(out_res.data))
		else $error("result changed under stall");
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		in_req.ready == (!out_res.valid || out_res.ready))
		else $error("ready does not follow output stage");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_res.valid && !out_res.data.derive_ok |-> out_res.data.password == '0)
		else $error("invalid result carries a password");
endmodule
